@@ src/pmi2d_pkg.sv @@
// shared types, constants and helpers for the 2d point mass integrator
package pmi2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int RATE_W    = 8;

    localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_ADD_FORCE  = 3'd0,
        ACT_APPLY      = 3'd1,
        ACT_ACCELERATE = 3'd2,
        ACT_MOVE       = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_LOAD_POS   = 3'd5,
        ACT_LOAD_VEL   = 3'd6,
        ACT_LOAD_ACC   = 3'd7
    } t_action;

    typedef enum logic {
        CFG_BODY_MASS = 1'b0,
        CFG_STEP_RATE = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETUP,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } t_state;

    // saturating add of a 32-bit value and a sign-extended 34-bit addend, msb is overflow
    function automatic logic [DATA_W:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W+1:0] b);
        logic [DATA_W+1:0] s;
        begin
            s = {{2{a[DATA_W-1]}}, a} + b;
            if (!s[DATA_W+1] && (s[DATA_W:DATA_W-1] != 2'b00)) begin
                sat_add = {1'b1, S_MAX};
            end else if (s[DATA_W+1] && (s[DATA_W:DATA_W-1] != 2'b11)) begin
                sat_add = {1'b1, S_MIN};
            end else begin
                sat_add = {1'b0, s[DATA_W-1:0]};
            end
        end
    endfunction

endpackage

@@ src/point_mass_integrator_2d.sv @@
// euler point mass integrator in 2d with one shared bit-serial divider
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | i_in_valid, o_in_ready, action, x, y      | in
//  out     | o_out_valid, i_out_ready, state and flags | out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_wdata        | in
//
// add force, clear, loads and a zero-mass apply pass exec; done loads the result
// apply forces at nonzero mass, accelerate and move run the restoring divider
// once per axis (setup, div, fix), one quotient bit a cycle
// o_in_ready is high only in idle; a stalled output holds the block in its last step
// synchronous active-low reset clears body, flags and control; loads cfg defaults
module point_mass_integrator_2d (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_action,
    input  logic signed [pmi2d_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [pmi2d_pkg::DATA_W-1:0] i_y_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_pos_x,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_pos_y,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_vel_x,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_vel_y,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_acc_x,
    output logic signed [pmi2d_pkg::DATA_W-1:0] o_acc_y,
    output logic                                o_zero_mass_flag,
    output logic                                o_overflow_flag,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [pmi2d_pkg::DATA_W-1:0]        i_cfg_wdata
);
    import pmi2d_pkg::*;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_mass;
    logic [RATE_W-1:0] r_rate;

    logic [DATA_W-1:0] r_pos [2];
    logic [DATA_W-1:0] r_vel [2];
    logic [DATA_W-1:0] r_acc [2];
    logic [DATA_W-1:0] r_fs  [2];

    t_action           r_act;
    logic [DATA_W-1:0] r_xv, r_yv;
    logic              r_zm, r_ovf;
    logic              r_comp;

    logic [DIV_W-1:0]  r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_divisor;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;

    logic [DATA_W-1:0] r_out_pos [2];
    logic [DATA_W-1:0] r_out_vel [2];
    logic [DATA_W-1:0] r_out_acc [2];
    logic              r_out_zm, r_out_ovf, r_out_valid;

    logic in_acc, out_free, load_out, need_div;
    logic [DATA_W-1:0] op, op_mag;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] diff;
    logic              ge;
    logic [DATA_W-1:0] q_low, apply_val;
    logic              apply_ovf;
    logic [DATA_W+1:0] sq;
    logic [DATA_W-1:0] target;
    logic [DATA_W:0]   rate_sum;
    logic [DATA_W:0]   add_x, add_y;
    logic [RATE_W-1:0] rate_eff;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign need_div = ((t_action'(i_action) == ACT_APPLY) && (r_mass != '0))
                      || (t_action'(i_action) == ACT_ACCELERATE)
                      || (t_action'(i_action) == ACT_MOVE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = need_div ? ST_SETUP : ST_EXEC;
                end
            end
            ST_EXEC:  n_state = ST_DONE;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX:   n_state = r_comp ? ST_DONE : ST_SETUP;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_DONE: load_out   = out_free;
            default: begin
                o_in_ready = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    // divider operand and one restoring step
    always_comb begin
        case (r_act)
            ACT_APPLY:      op = r_fs[r_comp];
            ACT_ACCELERATE: op = r_acc[r_comp];
            default:        op = r_vel[r_comp];
        endcase
        op_mag   = op[DATA_W-1] ? DATA_W'(~op + DATA_W'(1)) : op;
        rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;
        rem_sh   = {r_rem, r_quo[DIV_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, r_divisor};
        ge       = !diff[DATA_W+1];
    end

    // result of one axis after the divider finishes, and the add force sums
    always_comb begin
        q_low     = r_quo[DATA_W-1:0];
        apply_ovf = 1'b0;
        if (r_neg) begin
            if ((|r_quo[DIV_W-1:DATA_W]) || (q_low[DATA_W-1] && (|q_low[DATA_W-2:0]))) begin
                apply_val = S_MIN;
                apply_ovf = 1'b1;
            end else begin
                apply_val = DATA_W'(~q_low + DATA_W'(1));
            end
        end else begin
            if (|r_quo[DIV_W-1:DATA_W-1]) begin
                apply_val = S_MAX;
                apply_ovf = 1'b1;
            end else begin
                apply_val = q_low;
            end
        end
        sq       = r_neg ? (DATA_W+2)'(~{2'b00, q_low} + (DATA_W+2)'(1)) : {2'b00, q_low};
        target   = (r_act == ACT_ACCELERATE) ? r_vel[r_comp] : r_pos[r_comp];
        rate_sum = sat_add(target, sq);
        add_x    = sat_add(r_fs[0], {{2{r_xv[DATA_W-1]}}, r_xv});
        add_y    = sat_add(r_fs[1], {{2{r_yv[DATA_W-1]}}, r_yv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mass      <= DATA_W'(65536);
            r_rate      <= RATE_W'(30);
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
                r_fs[i]  <= '0;
            end
            r_act  <= ACT_ADD_FORCE;
            r_zm   <= 1'b0;
            r_ovf  <= 1'b0;
            r_comp <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_BODY_MASS: r_mass <= i_cfg_wdata;
                    CFG_STEP_RATE: r_rate <= i_cfg_wdata[RATE_W-1:0];
                    default:       r_mass <= r_mass;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_act  <= t_action'(i_action);
                        r_xv   <= i_x_value;
                        r_yv   <= i_y_value;
                        r_zm   <= 1'b0;
                        r_ovf  <= 1'b0;
                        r_comp <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    case (r_act)
                        ACT_ADD_FORCE: begin
                            r_fs[0] <= add_x[DATA_W-1:0];
                            r_fs[1] <= add_y[DATA_W-1:0];
                            r_ovf   <= add_x[DATA_W] | add_y[DATA_W];
                        end
                        ACT_APPLY: r_zm <= 1'b1;
                        ACT_CLEAR: begin
                            for (int i = 0; i < 2; i++) begin
                                r_pos[i] <= '0;
                                r_vel[i] <= '0;
                                r_acc[i] <= '0;
                                r_fs[i]  <= '0;
                            end
                        end
                        ACT_LOAD_POS: begin
                            r_pos[0] <= r_xv;
                            r_pos[1] <= r_yv;
                        end
                        ACT_LOAD_VEL: begin
                            r_vel[0] <= r_xv;
                            r_vel[1] <= r_yv;
                        end
                        ACT_LOAD_ACC: begin
                            r_acc[0] <= r_xv;
                            r_acc[1] <= r_yv;
                        end
                        default: r_zm <= r_zm;
                    endcase
                end
                ST_SETUP: begin
                    r_neg <= op[DATA_W-1];
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIV_W);
                    if (r_act == ACT_APPLY) begin
                        r_quo     <= {op_mag, {FRAC_BITS{1'b0}}};
                        r_divisor <= r_mass;
                    end else begin
                        r_quo     <= {{FRAC_BITS{1'b0}}, op_mag};
                        r_divisor <= {{(DATA_W-RATE_W){1'b0}}, rate_eff};
                    end
                end
                ST_DIV: begin
                    r_rem <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                ST_FIX: begin
                    r_comp <= 1'b1;
                    case (r_act)
                        ACT_APPLY: begin
                            r_acc[r_comp] <= apply_val;
                            r_ovf         <= r_ovf | apply_ovf;
                            if (r_comp) begin
                                r_fs[0] <= '0;
                                r_fs[1] <= '0;
                            end
                        end
                        ACT_ACCELERATE: begin
                            r_vel[r_comp] <= rate_sum[DATA_W-1:0];
                            r_ovf         <= r_ovf | rate_sum[DATA_W];
                        end
                        default: begin
                            r_pos[r_comp] <= rate_sum[DATA_W-1:0];
                            r_ovf         <= r_ovf | rate_sum[DATA_W];
                        end
                    endcase
                end
                default: r_comp <= r_comp;
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pos <= r_pos;
            r_out_vel <= r_vel;
            r_out_acc <= r_acc;
            r_out_zm  <= r_zm;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pos_x          = r_out_pos[0];
    assign o_pos_y          = r_out_pos[1];
    assign o_vel_x          = r_out_vel[0];
    assign o_vel_y          = r_out_vel[1];
    assign o_acc_x          = r_out_acc[0];
    assign o_acc_y          = r_out_acc[1];
    assign o_zero_mass_flag = r_out_zm;
    assign o_overflow_flag  = r_out_ovf;

endmodule

@@ src/pmi2d_chk.sv @@
// port-level checker for the 2d point mass integrator and its bind
module pmi2d_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_pos_x,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_pos_y,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_vel_x,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_vel_y,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_acc_x,
    input logic signed [pmi2d_pkg::DATA_W-1:0] o_acc_y,
    input logic                                o_zero_mass_flag,
    input logic                                o_overflow_flag
);
    import pmi2d_pkg::*;

    // busy after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a beat is in progress");

    // a refused apply never saturates
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_mass_flag) |-> !o_overflow_flag)
        else $error("zero mass and overflow flags both set");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_vel_x) && $stable(o_vel_y)
            && $stable(o_acc_x) && $stable(o_acc_y)))
        else $error("stalled result changed");

    // reset clears the result valid and leaves the block ready for input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("result valid or block busy after reset");

endmodule

bind point_mass_integrator_2d pmi2d_chk u_pmi2d_chk (.*);
